@@ src/kss_pkg.sv @@
// kss_pkg: shared constants, types and the string length tables for the
// plucked-string bank
// depends on nothing
`timescale 1ns / 1ps

package kss_pkg;

  // defaults for the top level parameters
  localparam int NUM_STRINGS_DEF = 128;
  localparam int MAX_PERIOD_DEF  = 5395;
  localparam int SAMPLE_RATE_DEF = 44100;
  localparam int STORE_DEPTH_DEF = 98304;

  // field widths
  localparam int NOTE_W     = 7;
  localparam int AMP_W      = 15;
  localparam int SUM_W      = 23;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int SEED_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_STRINGS = 1 << NOTE_W;

  // pitch reference: note 69 is 440 Hz
  localparam int unsigned REF_HZ   = 440;
  localparam int unsigned REF_NOTE = 69;
  localparam int          WIDE_W   = 448;

  localparam logic [SEED_W-1:0] LFSR_MASK  = 32'h8020_0003;
  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd65274;

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // item modes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PLUCK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY_GAIN = 1'b0,
    REG_NOISE_SEED = 1'b1
  } cfg_reg_t;

  typedef int unsigned len_tab_t [MAX_STRINGS];

  typedef struct packed {
    logic              is_tick;
    logic [NOTE_W-1:0] note;
    logic [AMP_W-1:0]  amplitude;
  } cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              seed_load;
    logic [SEED_W-1:0] seed;
  } cfg_ctl_t;

  typedef struct packed {
    logic idle;
    logic in_tick;
    logic lfsr_zero;
  } back_stat_t;

  // exact test (440*p)^12 * 2^note <= rhs, rhs = rate^12 * 2^69
  function automatic logic period_fits(int unsigned p, int unsigned note,
                                       logic [WIDE_W-1:0] rhs);
    logic [WIDE_W-1:0] lhs;
    lhs = WIDE_W'(1);
    for (int k = 0; k < 12; k++) begin
      lhs = lhs * WIDE_W'(REF_HZ * p);
    end
    lhs = lhs << note;
    return lhs <= rhs;
  endfunction

  // line length per string: floor(rate / f), clamped, then cut to the room left
  function automatic len_tab_t build_line_len(int unsigned num_strings,
                                              int unsigned max_period,
                                              int unsigned rate_hz,
                                              int unsigned store_depth);
    len_tab_t          tab;
    logic [WIDE_W-1:0] rhs;
    int unsigned       base;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    int unsigned       room;
    rhs  = WIDE_W'(1);
    base = 0;
    for (int k = 0; k < 12; k++) begin
      rhs = rhs * WIDE_W'(rate_hz);
    end
    rhs = rhs << REF_NOTE;
    for (int n = 0; n < MAX_STRINGS; n++) begin
      tab[n] = 0;
      if (n < num_strings) begin
        lo = 0;
        hi = max_period;
        for (int it = 0; it < 14; it++) begin
          if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (period_fits(mid, n, rhs)) lo = mid;
            else                          hi = mid - 1;
          end
        end
        if (lo == 0) lo = 1;
        room = (base < store_depth) ? store_depth - base : 0;
        if (lo > room) lo = room;
        tab[n] = lo;
        base   = base + lo;
      end
    end
    return tab;
  endfunction

  // start address of each line, lines packed back to back
  function automatic len_tab_t build_line_base(len_tab_t len);
    len_tab_t    tab;
    int unsigned base;
    base = 0;
    for (int n = 0; n < MAX_STRINGS; n++) begin
      tab[n] = base;
      base   = base + len[n];
    end
    return tab;
  endfunction

endpackage

@@ src/kss_if.sv @@
// kss_if: valid/ready channels of the string bank (item, result, register write)
// depends on kss_pkg
`timescale 1ns / 1ps

interface kss_item_if import kss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [NOTE_W-1:0] note;
  logic [AMP_W-1:0]  amplitude;

  modport source (output valid, mode, note, amplitude, input ready);
  modport sink   (input valid, mode, note, amplitude, output ready);
endinterface

interface kss_result_if import kss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] sample_sum;

  modport source (output valid, sample_sum, input ready);
  modport sink   (input valid, sample_sum, output ready);
endinterface

interface kss_cfg_if import kss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/kss_front.sv @@
// kss_front: takes item beats, drops plucks of missing strings, queues commands
// depends on kss_pkg, kss_if
`timescale 1ns / 1ps

module kss_front import kss_pkg::*; #(
  parameter int NUM_STRINGS = NUM_STRINGS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  kss_item_if.sink item,
  output cmd_t  cmd,
  output logic  cmd_valid,
  input  logic  cmd_pop,
  output logic  queue_empty
);

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              accept;
  logic              keep;

  assign item.ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign accept     = item.valid && item.ready;
  // plucks beyond the bank are taken and dropped
  assign keep = accept &&
                ((item.mode == MODE_TICK) ||
                 ({1'b0, item.note} < (NOTE_W + 1)'(NUM_STRINGS)));

  assign cmd         = queue[rd_ptr];
  assign cmd_valid   = (count != '0);
  assign queue_empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (keep)    wr_ptr <= wr_ptr + 1'b1;
      if (cmd_pop) rd_ptr <= rd_ptr + 1'b1;
      if (keep && !cmd_pop)      count <= count + 1'b1;
      else if (!keep && cmd_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      queue[wr_ptr] <= '{is_tick:   (item.mode == MODE_TICK),
                         note:      item.note,
                         amplitude: item.amplitude};
    end
  end

endmodule

@@ src/kss_back.sv @@
// kss_back: string store, phase memory, noise source and the tick pipeline
// depends on kss_pkg, kss_if
`timescale 1ns / 1ps

module kss_back import kss_pkg::*; #(
  parameter int NUM_STRINGS = NUM_STRINGS_DEF,
  parameter int MAX_PERIOD  = MAX_PERIOD_DEF,
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  cfg_ctl_t   ctl,
  kss_result_if.source result,
  output back_stat_t stat
);

  localparam int STR_W = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;
  localparam int PH_W  = $clog2(MAX_PERIOD + 1);
  localparam int AW    = $clog2(STORE_DEPTH);
  localparam len_tab_t LINE_LEN =
    build_line_len(NUM_STRINGS, MAX_PERIOD, SAMPLE_RATE, STORE_DEPTH);
  localparam len_tab_t LINE_BASE = build_line_base(LINE_LEN);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PLUCK = 4'b0010,
    ST_TICK  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
  logic [PH_W-1:0]     phase_mem [NUM_STRINGS];
  logic [NUM_STRINGS-1:0] phase_valid;
  logic [NUM_STRINGS-1:0] plucked;

  logic [SEED_W-1:0] noise;
  logic [SEED_W-1:0] lfsr_next;
  logic [31:0]       noise_prod;
  logic [AW-1:0]     pl_addr;
  logic [PH_W-1:0]   pl_left;
  logic [AMP_W:0]    pl_span;

  logic take_pluck;
  logic take_tick;
  logic [PH_W-1:0] pluck_len;

  // tick pipeline
  logic [STR_W-1:0] issue_cnt;
  logic             v1;
  logic [STR_W-1:0] s1;
  logic [PH_W-1:0]  ph_raw;
  logic             ph_ok1;
  logic [PH_W-1:0]  len1;
  logic [AW-1:0]    base1;
  logic             live1;
  logic [PH_W-1:0]  ph_in;
  logic [PH_W-1:0]  ph;
  logic [PH_W:0]    ph_inc;
  logic [PH_W-1:0]  nx;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic [SAMPLE_W-1:0] a_rd;
  logic [SAMPLE_W-1:0] b_rd;
  logic [AW-1:0]    addr2;
  logic             live2;
  logic             pk2;
  logic [SAMPLE_W-1:0] a2;
  logic [SAMPLE_W-1:0] b2;
  logic [SAMPLE_W:0]   pair;
  logic [SAMPLE_W+GAIN_W:0] decay_prod;
  logic [SUM_W-1:0] sum;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [SAMPLE_W-1:0] wr_data;

  assign take_pluck = (state == ST_IDLE) && cmd_valid && !cmd.is_tick;
  assign take_tick  = (state == ST_IDLE) && cmd_valid && cmd.is_tick && !result.valid;
  assign cmd_pop    = take_pluck || take_tick;
  assign pluck_len  = PH_W'(LINE_LEN[cmd.note]);

  // galois lfsr, one step per entry written by a pluck
  assign lfsr_next  = {1'b0, noise[SEED_W-1:1]} ^ (noise[0] ? LFSR_MASK : '0);
  assign noise_prod = {16'b0, lfsr_next[SEED_W-1:SEED_W-16]} * {16'b0, pl_span};

  // stage 1: wrap the phase, form both read addresses
  assign ph_in  = ph_ok1 ? ph_raw : '0;
  assign len1   = PH_W'(LINE_LEN[NOTE_W'(s1)]);
  assign base1  = AW'(LINE_BASE[NOTE_W'(s1)]);
  assign live1  = v1 && (len1 != '0);
  assign ph     = (ph_in >= len1) ? '0 : ph_in;
  assign ph_inc = {1'b0, ph} + 1'b1;
  assign nx     = (ph_inc >= {1'b0, len1}) ? '0 : ph_inc[PH_W-1:0];
  assign addr_a = base1 + AW'(ph);
  assign addr_b = base1 + AW'(nx);

  // stage 2: lines never plucked read as zero
  assign a2         = pk2 ? a_rd : '0;
  assign b2         = pk2 ? b_rd : '0;
  assign pair       = {1'b0, a2} + {1'b0, b2};
  assign decay_prod = pair * ctl.gain;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pl_addr;
    wr_data = noise_prod[31:16];
    if (state == ST_PLUCK) begin
      wr_en = 1'b1;
    end else if (live2 && pk2) begin
      wr_en   = 1'b1;
      wr_addr = addr2;
      wr_data = decay_prod[SAMPLE_W+GAIN_W:GAIN_W+1];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_pluck && (pluck_len != '0)) state_next = ST_PLUCK;
        else if (take_tick)                  state_next = ST_TICK;
      end
      ST_PLUCK: begin
        if (pl_left == '0) state_next = ST_IDLE;
      end
      ST_TICK: begin
        if (issue_cnt == STR_W'(NUM_STRINGS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1 && !live2) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      noise        <= SEED_RESET;
      plucked      <= '0;
      phase_valid  <= '0;
      v1           <= 1'b0;
      live2        <= 1'b0;
      issue_cnt    <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= (state == ST_TICK);
      live2 <= live1;
      if (live1) phase_valid[s1] <= 1'b1;

      if (ctl.seed_load) begin
        noise <= (ctl.seed == '0) ? SEED_RESET : ctl.seed;
      end else if (state == ST_PLUCK) begin
        noise <= lfsr_next;
      end

      if (take_pluck) plucked[cmd.note[STR_W-1:0]] <= 1'b1;

      if (take_tick)               issue_cnt <= '0;
      else if (state == ST_TICK)   issue_cnt <= issue_cnt + 1'b1;

      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end else if ((state == ST_DRAIN) && !v1 && !live2) begin
        result.valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_pluck) begin
      pl_addr <= AW'(LINE_BASE[cmd.note]);
      pl_left <= pluck_len - 1'b1;
      pl_span <= {cmd.amplitude, 1'b0};
    end else if (state == ST_PLUCK) begin
      pl_addr <= pl_addr + 1'b1;
      pl_left <= pl_left - 1'b1;
    end
    s1     <= issue_cnt;
    ph_ok1 <= phase_valid[issue_cnt];
    addr2  <= addr_a;
    pk2    <= plucked[s1];
    if (take_tick)  sum <= '0;
    else if (live2) sum <= sum + SUM_W'(a2);
    if ((state == ST_DRAIN) && !v1 && !live2) result.sample_sum <= sum;
  end

  // phase memory: read for the string being issued, write back the one behind it
  always_ff @(posedge clk) begin
    if (live1) phase_mem[s1] <= nx;
    ph_raw <= phase_mem[issue_cnt];
  end

  // string store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    a_rd <= store_mem[addr_a];
    b_rd <= store_mem[addr_b];
  end

  assign stat.idle      = (state == ST_IDLE);
  assign stat.in_tick   = (state == ST_TICK) || (state == ST_DRAIN);
  assign stat.lfsr_zero = (noise == '0);

endmodule

@@ src/karplus_strong_string_bank.sv @@
// a tick beat accepted with the back free raises its sum once the sweep has
// drained (one string issued a cycle into a three-stage pipeline); the back takes
// no new command until idle again, and a tick also waits until the last sum is
// taken; a pluck holds it while the write port fills its line (up to MAX_PERIOD)
// reset: synchronous, active high; clears queue, phases, pluck flags and noise
// state; no sweep of the store, unplucked lines read as zero through their flags
`timescale 1ns / 1ps

module karplus_strong_string_bank import kss_pkg::*; #(
  parameter int NUM_STRINGS = NUM_STRINGS_DEF,
  parameter int MAX_PERIOD  = MAX_PERIOD_DEF,
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  kss_item_if.sink     item,
  kss_result_if.source result,
  kss_cfg_if.sink      cfg
);

  // front to back command path
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_pop;
  logic       queue_empty;
  back_stat_t bstat;

  // register file
  logic [GAIN_W-1:0] decay_gain;
  cfg_ctl_t          ctl;
  logic              cfg_we;

  // register writes only with nothing queued or running, so a seed load
  // never lands in the middle of a pluck
  assign cfg.ready = queue_empty && bstat.idle;
  assign cfg_we    = cfg.valid && cfg.ready;

  // the seed is not kept, writing it loads the noise state directly
  assign ctl.gain      = decay_gain;
  assign ctl.seed_load = cfg_we && (cfg_reg_t'(cfg.index) == REG_NOISE_SEED);
  assign ctl.seed      = cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_DECAY_GAIN: decay_gain <= cfg.data[GAIN_W-1:0];
        REG_NOISE_SEED: decay_gain <= decay_gain;
        default:        decay_gain <= decay_gain;
      endcase
    end
  end

  // front: takes beats, filters plucks, short command queue
  kss_front #(
    .NUM_STRINGS (NUM_STRINGS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .queue_empty (queue_empty)
  );

  // back: pluck fill and tick sweep over the store, result register
  kss_back #(
    .NUM_STRINGS (NUM_STRINGS),
    .MAX_PERIOD  (MAX_PERIOD),
    .SAMPLE_RATE (SAMPLE_RATE),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .ctl       (ctl),
    .result    (result),
    .stat      (bstat)
  );

`ifndef NO_ASSERTIONS
  // the noise lfsr must never lock up at zero
  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    !bstat.lfsr_zero)
    else $error("noise lfsr reached zero");

  // a result only appears at the end of a tick sweep
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(bstat.in_tick))
    else $error("result raised outside a tick");

  // the back never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");
`endif

endmodule

@@ sim/karplus_strong_string_bank_tb.sv @@
// karplus_strong_string_bank_tb: self-checking bench for the plucked-string bank,
// a queue-fed driver, a random result sink and a monitor that scores every sum
// depends on kss_pkg, kss_if and the karplus_strong_string_bank top level
`timescale 1ns / 1ps

module karplus_strong_string_bank_tb;
  import kss_pkg::*;

  localparam int NSTR  = NUM_STRINGS_DEF;
  localparam int MAXP  = MAX_PERIOD_DEF;
  localparam int RATE  = SAMPLE_RATE_DEF;
  localparam int DEPTH = STORE_DEPTH_DEF;

  localparam logic [31:0] NOISE_TAPS = 32'h8020_0003;

  // one tick takes the whole bank plus the pipeline
  localparam int TICK_CYCLES   = NSTR + 5;
  // a pluck of the longest line can still be writing when the last sum is out
  localparam int SETTLE_CYCLES = MAXP + 2 * TICK_CYCLES + 16;
  localparam int TAIL_CYCLES   = 2 * TICK_CYCLES;
  localparam int HOLD_CYCLES   = 1000;
  // cycles with no beat anywhere before giving up
  localparam int STALL_LIMIT   = 100000;

  typedef struct packed {
    logic              mode;
    logic [NOTE_W-1:0] note;
    logic [AMP_W-1:0]  amp;
  } bank_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kss_item_if   item_bus ();
  kss_result_if sum_bus ();
  kss_cfg_if    reg_bus ();

  karplus_strong_string_bank u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (sum_bus),
    .cfg    (reg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // string bank model: delay lines packed into one store, phases, noise lfsr
  // ---------------------------------------------------------------------------
  bit [15:0]   line_mem   [DEPTH];
  bit [12:0]   line_pos   [NSTR];
  int unsigned line_start [NSTR];
  int unsigned line_size  [NSTR];
  bit [31:0]   lfsr_now;
  bit [15:0]   gain_now;

  logic [SUM_W-1:0] expected_sums [$];
  bank_cmd_t        cmd_queue [$];

  int  items_sent;
  int  items_taken;
  int  sums_checked;
  int  mismatches;
  int  idle_pct;
  bit  item_beat;
  bit  hold_request;
  int  hold_left;
  int  stall_cycles;

  // exact pitch test: (440*p)^12 * 2^note <= rate^12 * 2^69
  function automatic bit pitch_ok(int unsigned p, int n, bit [511:0] limit);
    bit [511:0] acc;
    acc = 512'd1;
    repeat (12) acc = acc * 512'(440 * p);
    acc = acc << n;
    return acc <= limit;
  endfunction

  // line lengths from a float estimate, nudged onto the exact floor
  task automatic build_string_map();
    bit [511:0]  limit;
    int unsigned next_base;
    int unsigned room;
    int          p;
    real         hz;
    limit = 512'd1;
    repeat (12) limit = limit * 512'(RATE);
    limit     = limit << 69;
    next_base = 0;
    for (int n = 0; n < NSTR; n++) begin
      hz = 440.0 * (2.0 ** ((n - 69) / 12.0));
      p  = $rtoi(RATE / hz);
      while (pitch_ok(p + 1, n, limit)) p++;
      while (p > 0 && !pitch_ok(p, n, limit)) p--;
      if (p > MAXP) p = MAXP;
      if (p == 0) p = 1;
      // store full: cut the line to what is left
      room = (next_base < DEPTH) ? DEPTH - next_base : 0;
      if (p > room) p = room;
      line_start[n] = next_base;
      line_size[n]  = p;
      next_base     = next_base + p;
    end
  endtask

  // fill one line with scaled noise, phase untouched
  task automatic pluck_string(int unsigned note, int unsigned amp);
    int unsigned span;
    int unsigned r;
    if (note >= NSTR) return;
    span = 2 * amp;
    for (int unsigned j = 0; j < line_size[note]; j++) begin
      lfsr_now = lfsr_now[0] ? ((lfsr_now >> 1) ^ NOISE_TAPS) : (lfsr_now >> 1);
      r        = lfsr_now[31:16];
      line_mem[line_start[note] + j] = 16'((r * span) >> 16);
    end
  endtask

  // one output sample: sum every string at its phase, damp and advance
  task automatic tick_bank();
    int unsigned       acc;
    int unsigned       len;
    int unsigned       ph;
    int unsigned       nx;
    int unsigned       a;
    int unsigned       b;
    longint unsigned   damped;
    acc = 0;
    for (int s = 0; s < NSTR; s++) begin
      len = line_size[s];
      if (len != 0) begin
        ph = line_pos[s];
        if (ph >= len) ph = 0;
        nx  = (ph + 1 >= len) ? 0 : ph + 1;
        a   = line_mem[line_start[s] + ph];
        b   = line_mem[line_start[s] + nx];
        acc = acc + a;
        damped = (longint'(a + b) * longint'(gain_now)) >> 17;
        line_mem[line_start[s] + ph] = 16'(damped);
        line_pos[s] = 13'(nx);
      end
    end
    expected_sums.push_back(SUM_W'(acc));
  endtask

  // ---------------------------------------------------------------------------
  // item driver: pops the pending queue at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || item_beat) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        bank_cmd_t c;
        c = cmd_queue.pop_front();
        item_bus.valid     <= 1'b1;
        item_bus.mode      <= c.mode;
        item_bus.note      <= c.note;
        item_bus.amplitude <= c.amp;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random gaps, plus one long hold-off counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      sum_bus.ready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        sum_bus.ready <= 1'b0;
      end else begin
        sum_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: register beats, item beats into the model, sums against the model
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic [SUM_W-1:0] want;
    item_beat = !rst && item_bus.valid && item_bus.ready;
    if (!rst && reg_bus.valid && reg_bus.ready) begin
      case (cfg_reg_t'(reg_bus.index))
        REG_DECAY_GAIN: gain_now = reg_bus.data[GAIN_W-1:0];
        // zero seed would lock the lfsr, loads one instead
        REG_NOISE_SEED: lfsr_now = (reg_bus.data == '0) ? 32'd1 : reg_bus.data;
        default: ;
      endcase
    end
    if (!rst && sum_bus.valid && sum_bus.ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: sample_sum with nothing expected, expected none, got %0d",
                 $time, sum_bus.sample_sum);
        mismatches++;
      end else begin
        want = expected_sums.pop_front();
        if (sum_bus.sample_sum !== want) begin
          $display("%0t: sample_sum mismatch, expected %0d, got %0d",
                   $time, want, sum_bus.sample_sum);
          mismatches++;
        end
      end
      sums_checked++;
    end
    if (item_beat) begin
      if (item_bus.mode == MODE_PLUCK) pluck_string(item_bus.note, item_bus.amplitude);
      else tick_bank();
      items_taken++;
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (sum_bus.valid && sum_bus.ready)
        || (reg_bus.valid && reg_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("karplus_strong_string_bank_tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_cmd(logic mode, int unsigned note, int unsigned amp);
    bank_cmd_t c;
    c.mode = mode;
    c.note = NOTE_W'(note);
    c.amp  = AMP_W'(amp);
    cmd_queue.push_back(c);
    items_sent++;
  endtask

  // mostly the shorter upper strings, now and then any note
  function automatic int unsigned pick_note();
    if ($urandom_range(9) == 0) return $urandom_range(127);
    return $urandom_range(127, 36);
  endfunction

  // pluck volume with the extremes weighted up
  function automatic int unsigned pick_level();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 32767;
      default: return $urandom_range(32767);
    endcase
  endfunction

  // pluck-then-listen runs, with some loose ticks and bare plucks mixed in
  task automatic play_random(int count);
    int left;
    int run;
    left = count;
    while (left > 0) begin
      if ($urandom_range(3) != 0) begin
        add_cmd(MODE_PLUCK, pick_note(), pick_level());
        run = $urandom_range(6, 1);
        repeat (run) add_cmd(MODE_TICK, $urandom_range(127), $urandom_range(32767));
        left = left - 1 - run;
      end else begin
        if ($urandom_range(1) == 1) add_cmd(MODE_TICK, $urandom_range(127), $urandom_range(32767));
        else add_cmd(MODE_PLUCK, pick_note(), pick_level());
        left--;
      end
    end
  endtask

  // sender pauses until every item is taken and every sum is back
  task automatic wait_idle();
    while (items_taken != items_sent || expected_sums.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= value;
    do @(posedge clk); while (!reg_bus.ready);
    @(negedge clk);
    reg_bus.valid <= 1'b0;
  endtask

  task automatic next_setting(logic [GAIN_W-1:0] gain, logic [SEED_W-1:0] seed);
    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_DECAY_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_NOISE_SEED, CFG_DATA_W'(seed));
  endtask

  initial begin
    item_bus.valid     = 1'b0;
    item_bus.mode      = MODE_TICK;
    item_bus.note      = '0;
    item_bus.amplitude = '0;
    sum_bus.ready      = 1'b0;
    reg_bus.valid      = 1'b0;
    reg_bus.index      = REG_DECAY_GAIN;
    reg_bus.data       = '0;
    idle_pct           = 9;
    hold_request       = 1'b0;
    hold_left          = 0;

    build_string_map();
    gain_now = GAIN_RESET;
    lfsr_now = SEED_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset register values
    add_cmd(MODE_TICK, 0, 0);             // silent bank sums to zero
    add_cmd(MODE_PLUCK, 127, 32767);      // shortest line, loudest pluck
    repeat (4) add_cmd(MODE_TICK, 0, 0);  // phase wraps on the short line
    add_cmd(MODE_PLUCK, 0, 32767);        // longest line
    add_cmd(MODE_TICK, 0, 0);
    add_cmd(MODE_PLUCK, 69, 0);           // zero amplitude on an unplucked line
    add_cmd(MODE_PLUCK, 127, 0);          // re-pluck to silence
    add_cmd(MODE_TICK, 0, 0);
    add_cmd(MODE_PLUCK, 1, 1);
    add_cmd(MODE_PLUCK, 64, 16384);
    add_cmd(MODE_PLUCK, 126, 21845);
    add_cmd(MODE_PLUCK, 63, 10922);
    add_cmd(MODE_TICK, 127, 32767);       // tick ignores note and amplitude
    add_cmd(MODE_TICK, 0, 0);
    add_cmd(MODE_PLUCK, 127, 32767);
    repeat (4) add_cmd(MODE_TICK, 0, 0);

    // slowest decay, zero seed
    next_setting(16'hFFFF, 32'd0);
    play_random(150);

    // full loss, all-ones seed, no idling on either side
    next_setting(16'h0000, 32'hFFFF_FFFF);
    idle_pct = 0;
    play_random(100);

    // random setting; sink holds off long enough to back the bank up
    next_setting(GAIN_W'($urandom), $urandom);
    idle_pct     = 9;
    hold_request = 1'b1;
    play_random(200);

    // mid gain, back to the reset seed
    next_setting(16'h8000, SEED_RESET);
    play_random(150);

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("karplus_strong_string_bank_tb passed");
    end else begin
      $display("karplus_strong_string_bank_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/kss_pkg.sv
src/kss_if.sv
src/kss_front.sv
src/kss_back.sv
src/karplus_strong_string_bank.sv
sim/karplus_strong_string_bank_tb.sv
